>>> rtl/wttb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wttb_pkg
// types and constants shared by the transition table builder
// ----------------------------------------------------------------------------
package wttb_pkg;

	localparam int unsigned ONE_Q16 = 65536;

	typedef struct packed {
		logic [31:0] wealth;
		logic [31:0] bid_amount;
		logic        last_entry;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  entry_index;
		logic [5:0]  reject_index;
		logic [16:0] reject_weight;
		logic [5:0]  bid_index;
		logic [16:0] bid_weight;
		logic        weight_clipped;
		logic        last_result;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // write input item into the grid
		logic clr_count; // grid done
		logic sel_bid;   // 0 reject search, 1 bid search
		logic setup;     // set search bounds and target
		logic probe;     // issue a read of w[mid]
		logic step;      // apply a probe compare
		logic rd_lo;     // read w[lo]
		logic rd_hi;     // read w[hi]
		logic div_init;  // start division
		logic div_step;  // one quotient bit
		logic finish;    // latch bracket result
		logic emit;      // present result
		logic next_k;    // advance entry
		logic rd_k;      // read w[k], b[k]
		logic rd_top;    // read w[0]
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic search_done; // lo + 1 >= hi
		logic last_k;      // k + 1 == n
		logic div_done;
	} sts_t;

endpackage

>>> rtl/wealth_transition_table_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wealth_transition_table_builder
// loads a wealth grid and emits bracket index and weight per entry
// ----------------------------------------------------------------------------
// channel   signals                       handshake
// config    omega_we, omega               write when omega_we high
// input     start, busy, in_item          start high and busy low
// result    done, out_item                one cycle strobe on done
//
// loading accepts one entry per cycle while start is high; after the last entry
// the top entry is read, then each result reads its entry and runs both
// searches (up to six probes each): per search setup, a read, compare and
// check per probe, a final check, two reads and a serial division, then the
// strobe; the single read port and the bit-serial divider set this order.
// busy stays high until the last result; reset clears count, omega, sequencer.
// ----------------------------------------------------------------------------
module wealth_transition_table_builder import wttb_pkg::*; #(
	parameter int GRID_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        omega_we,
	input  logic [31:0] omega,
	input  logic        start,
	input  in_item_t    in_item,
	output logic        busy,
	output logic        done,
	output out_item_t   out_item
);

	ctl_t ctl;
	sts_t sts;

	wttb_control u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .in_item(in_item),
		.sts(sts), .busy(busy), .done(done), .ctl(ctl)
	);

	wttb_datapath #(.GRID_DEPTH(GRID_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(omega_we), .cfg_data(omega),
		.in_item(in_item), .ctl(ctl), .sts(sts), .result(out_item)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without busy");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> !busy) else $error("load while busy");
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_item.reject_weight <= 17'(ONE_Q16)) &&
		(out_item.bid_weight <= 17'(ONE_Q16))) else $error("weight above one");

endmodule

>>> rtl/wttb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wttb_datapath
// grid memory, bracket search registers and serial weight divider
// ----------------------------------------------------------------------------
module wttb_datapath import wttb_pkg::*; #(
	parameter int GRID_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	input  in_item_t    in_item,
	input  ctl_t        ctl,
	output sts_t        sts,
	output out_item_t   result
);

	localparam int IW = $clog2(GRID_DEPTH);
	localparam int CW = $clog2(GRID_DEPTH + 1);

	logic [31:0] wmem [GRID_DEPTH];
	logic [31:0] bmem [GRID_DEPTH];
	logic [31:0] rd_w_q, rd_b_q;
	logic [IW-1:0] raddr;

	logic [31:0] omega_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] k_q, lo_q, hi_q;
	logic [31:0] wk_q, bk_q, wtop_q, wlo_q;
	logic signed [34:0] tgt_q;
	logic trivial_q;
	logic [1:0] rdsel_q;
	logic [5:0] rej_idx_q;
	logic [16:0] rej_w_q;
	logic rej_clip_q;
	logic [33:0] num_q, den_q, rem_q;
	logic [16:0] quo_q;
	logic [4:0] dcnt_q;
	logic [16:0] w_res;
	logic clip_res;
	logic [IW:0] sum;
	logic [IW-1:0] mid;
	logic [IW-1:0] n_m1;

	assign n_m1 = IW'(count_q - CW'(1));
	assign sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = sum[IW:1];

	// memory: one write port, one registered read port
	always_comb begin
		raddr = k_q;
		if (ctl.probe) raddr = mid;
		else if (ctl.rd_lo) raddr = lo_q;
		else if (ctl.rd_hi) raddr = hi_q;
		else if (ctl.rd_top) raddr = '0;
	end

	always_ff @(posedge clk) begin
		if (ctl.load && count_q < CW'(GRID_DEPTH)) begin
			wmem[count_q[IW-1:0]] <= in_item.wealth;
			bmem[count_q[IW-1:0]] <= in_item.bid_amount;
		end
		rd_w_q <= wmem[raddr];
		rd_b_q <= bmem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			omega_q <= '0;
			count_q <= '0;
			k_q     <= '0;
			rdsel_q <= '0;
		end else begin
			if (cfg_we) omega_q <= cfg_data;
			if (ctl.load && count_q < CW'(GRID_DEPTH)) count_q <= count_q + CW'(1);
			if (ctl.clr_count) begin
				count_q <= '0;
				k_q <= '0;
			end else if (ctl.next_k) begin
				k_q <= k_q + IW'(1);
			end
			rdsel_q <= {ctl.rd_k, ctl.rd_top};
		end
	end

	logic signed [34:0] t_rej, t_bid;
	logic change_pos;
	assign t_rej = $signed({3'b0, wk_q}) + $signed({3'b0, omega_q}) - $signed({3'b0, bk_q});
	assign t_bid = $signed({3'b0, wk_q}) - $signed({3'b0, bk_q});
	assign change_pos = omega_q > bk_q;

	logic signed [34:0] nm, dn;
	always_comb begin
		nm = tgt_q - $signed({3'b0, rd_w_q});
		dn = $signed({3'b0, wlo_q}) - $signed({3'b0, rd_w_q});
	end

	always_ff @(posedge clk) begin
		if (rdsel_q[1]) begin
			wk_q <= rd_w_q;
			bk_q <= rd_b_q;
		end
		if (rdsel_q[0]) wtop_q <= rd_w_q;
		if (ctl.setup) begin
			trivial_q <= 1'b0;
			if (ctl.sel_bid) begin
				tgt_q <= t_bid;
				lo_q  <= k_q;
				hi_q  <= sts.last_k ? k_q : n_m1;
			end else begin
				tgt_q <= t_rej;
				if (k_q == '0 || $signed({3'b0, wtop_q}) < t_rej) begin
					trivial_q <= 1'b1;
					lo_q <= '0;
					hi_q <= '0;
				end else if (change_pos) begin
					lo_q <= '0;
					hi_q <= k_q;
				end else begin
					lo_q <= k_q;
					hi_q <= n_m1;
				end
			end
		end
		if (ctl.step) begin
			if ($signed({3'b0, rd_w_q}) < tgt_q) hi_q <= mid;
			else lo_q <= mid;
		end
		if (ctl.rd_hi) wlo_q <= rd_w_q; // read issued for hi, data is w[lo]
		if (ctl.div_init) begin
			quo_q <= '0;
			rem_q <= '0;
			dcnt_q <= 5'd17;
			if (dn < 0) begin
				num_q <= 34'(-nm);
				den_q <= 34'(-dn);
			end else begin
				num_q <= 34'(nm);
				den_q <= 34'(dn);
			end
			if (lo_q >= hi_q || dn == 0) begin
				num_q <= 34'd1;
				den_q <= 34'd1;
			end else if ((dn < 0 ? -nm : nm) < 0) begin
				num_q <= 34'd0;
				den_q <= 34'd1;
			end
		end
		if (ctl.div_step) begin
			// restoring division of num * 2^16 by den, num <= den
			logic [34:0] r2;
			r2 = (dcnt_q == 5'd17) ? {1'b0, num_q} : {rem_q, 1'b0};
			if (r2 >= {1'b0, den_q}) begin
				rem_q <= 34'(r2 - {1'b0, den_q});
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				rem_q <= r2[33:0];
				quo_q <= {quo_q[15:0], 1'b0};
			end
			dcnt_q <= dcnt_q - 5'd1;
		end
		if (ctl.finish && !ctl.sel_bid) begin
			rej_idx_q  <= 6'(lo_q);
			rej_w_q    <= w_res;
			rej_clip_q <= clip_res;
		end
		if (ctl.finish && ctl.sel_bid) begin
			result.entry_index    <= 6'(k_q);
			result.reject_index   <= rej_idx_q;
			result.reject_weight  <= rej_w_q;
			result.bid_index      <= 6'(lo_q);
			result.bid_weight     <= w_res;
			result.weight_clipped <= rej_clip_q | clip_res;
			result.last_result    <= sts.last_k;
		end
	end

	// saturation: num > den clips high, num < 0 already forced to zero
	logic num_neg_q, over_q;
	always_ff @(posedge clk) begin
		if (ctl.div_init) begin
			num_neg_q <= 1'b0;
			over_q <= 1'b0;
			if (!(trivial_q || lo_q >= hi_q || dn == 0)) begin
				num_neg_q <= (dn < 0 ? -nm : nm) < 0;
				over_q <= (dn < 0 ? -nm : nm) > (dn < 0 ? -dn : dn);
			end
		end
	end

	always_comb begin
		clip_res = num_neg_q | over_q;
		if (over_q) w_res = 17'(ONE_Q16);
		else if (num_neg_q) w_res = '0;
		else w_res = quo_q;
	end

	assign sts.search_done = ({1'b0, lo_q} + (IW+1)'(1)) >= {1'b0, hi_q};
	assign sts.last_k = ({1'b0, k_q} + (IW+1)'(1)) == (IW+1)'(count_q);
	assign sts.div_done = dcnt_q == 5'd0;

endmodule

>>> rtl/wttb_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wttb_control
// sequencer for grid loading, bracket searches and result strobes
// ----------------------------------------------------------------------------
module wttb_control import wttb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  in_item_t in_item,
	input  sts_t     sts,
	output logic     busy,
	output logic     done,
	output ctl_t     ctl
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RDTOP = 4'd1;
	localparam logic [3:0] S_RDK   = 4'd2;
	localparam logic [3:0] S_WAITK = 4'd3;
	localparam logic [3:0] S_SETUP = 4'd4;
	localparam logic [3:0] S_CHK   = 4'd5;
	localparam logic [3:0] S_PROBE = 4'd6;
	localparam logic [3:0] S_STEP  = 4'd7;
	localparam logic [3:0] S_RDLO  = 4'd8;
	localparam logic [3:0] S_RDHI  = 4'd9;
	localparam logic [3:0] S_DINIT = 4'd10;
	localparam logic [3:0] S_DIV   = 4'd11;
	localparam logic [3:0] S_FIN   = 4'd12;
	localparam logic [3:0] S_EMIT  = 4'd13;

	logic [3:0] state_q, state_d;
	logic sel_q, sel_d, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			done_q  <= ctl.emit;
		end
	end

	always_comb begin
		ctl = '0;
		state_d = state_q;
		sel_d = sel_q;
		ctl.sel_bid = sel_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					if (in_item.last_entry) state_d = S_RDTOP;
				end
			end
			S_RDTOP: begin
				ctl.rd_top = 1'b1;
				state_d = S_RDK;
			end
			S_RDK: begin
				ctl.rd_k = 1'b1;
				state_d = S_WAITK;
			end
			S_WAITK: begin
				sel_d = 1'b0;
				state_d = S_SETUP;
			end
			S_SETUP: begin
				ctl.setup = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				state_d = sts.search_done ? S_RDLO : S_PROBE;
			end
			S_PROBE: begin
				ctl.probe = 1'b1;
				state_d = S_STEP;
			end
			S_STEP: begin
				ctl.probe = 1'b1;
				ctl.step = 1'b1;
				state_d = S_CHK;
			end
			S_RDLO: begin
				ctl.rd_lo = 1'b1;
				state_d = S_RDHI;
			end
			S_RDHI: begin
				ctl.rd_hi = 1'b1;
				state_d = S_DINIT;
			end
			S_DINIT: begin
				ctl.div_init = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) state_d = S_FIN;
				else ctl.div_step = 1'b1;
			end
			S_FIN: begin
				ctl.finish = 1'b1;
				if (sel_q) begin
					state_d = S_EMIT;
				end else begin
					sel_d = 1'b1;
					state_d = S_SETUP;
				end
			end
			S_EMIT: begin
				ctl.emit = 1'b1;
				if (sts.last_k) begin
					ctl.clr_count = 1'b1;
					state_d = S_IDLE;
				end else begin
					ctl.next_k = 1'b1;
					state_d = S_RDK;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the wealth transition table builder against a bracket predictor: grids
// of entries are loaded, and each result's indices, weights and flags compare
// with the oldest prediction; omega is changed between grids while idle
// ----------------------------------------------------------------------------
module tb;
	import wttb_pkg::*;

	localparam int DEPTH = 64;
	localparam int LIMIT = 4000000;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      omega_we = 0;
	logic [31:0] omega = 0;
	logic      start = 0;
	in_item_t  in_item = '0;
	logic      busy;
	logic      done;
	out_item_t out_item;

	wealth_transition_table_builder #(.GRID_DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n), .omega_we(omega_we), .omega(omega),
		.start(start), .in_item(in_item), .busy(busy), .done(done), .out_item(out_item)
	);

	logic [31:0] grid_wealth [DEPTH];
	logic [31:0] grid_bid [DEPTH];
	int unsigned grid_count = 0;
	logic [31:0] omega_model = 0;
	out_item_t   pending_results [$];
	int          fail_count = 0;
	longint      cycle_count = 0;

	initial forever #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("FAIL wealth_transition_table_builder");
			$finish;
		end
	end

	task automatic find_bracket(input int unsigned lo_in, input int unsigned hi_in,
		input longint target, output logic [5:0] idx, output logic [16:0] wt,
		output logic clip);
		int unsigned lo, hi, mid;
		longint num, den;
		lo = lo_in;
		hi = hi_in;
		while (lo + 1 < hi) begin
			mid = (lo + hi) / 2;
			if (longint'(grid_wealth[mid]) < target) hi = mid;
			else lo = mid;
		end
		idx = lo[5:0];
		wt = 17'(ONE_Q16);
		clip = 0;
		if (lo < hi) begin
			num = target - longint'(grid_wealth[hi]);
			den = longint'(grid_wealth[lo]) - longint'(grid_wealth[hi]);
			if (den != 0) begin
				if (den < 0) begin
					den = -den;
					num = -num;
				end
				if (num < 0) begin
					wt = 0;
					clip = 1;
				end else if (num > den) begin
					wt = 17'(ONE_Q16);
					clip = 1;
				end else begin
					wt = 17'((num * ONE_Q16) / den);
				end
			end
		end
	endtask

	task automatic predict_table();
		out_item_t r;
		longint change, after;
		logic c1, c2;
		for (int unsigned k = 0; k < grid_count; k++) begin
			r = '0;
			c1 = 0;
			c2 = 0;
			r.entry_index = k[5:0];
			r.reject_weight = 17'(ONE_Q16);
			if (k != 0) begin
				change = longint'(omega_model) - longint'(grid_bid[k]);
				after = longint'(grid_wealth[k]) + change;
				if (longint'(grid_wealth[0]) < after) ;
				else if (change > 0)
					find_bracket(0, k, after, r.reject_index, r.reject_weight, c1);
				else
					find_bracket(k, grid_count - 1, after, r.reject_index, r.reject_weight, c1);
			end
			if (k + 1 < grid_count) begin
				after = longint'(grid_wealth[k]) - longint'(grid_bid[k]);
				find_bracket(k, grid_count - 1, after, r.bid_index, r.bid_weight, c2);
			end else begin
				r.bid_index = k[5:0];
				r.bid_weight = 17'(ONE_Q16);
			end
			r.weight_clipped = c1 | c2;
			r.last_result = (k + 1 == grid_count);
			pending_results = {pending_results, r};
		end
		grid_count = 0;
	endtask

	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result %p", $time, out_item);
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (out_item !== exp_r) begin
					$display("%0t mismatch expected %p actual %p", $time, exp_r, out_item);
					fail_count++;
				end
			end
		end
	end

	task automatic idle_gap();
		int unsigned n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
		repeat (n) @(negedge clk);
	endtask

	// one transaction; start stays high across back-to-back sends
	task automatic send_entry(input logic [31:0] w, input logic [31:0] b,
		input logic last, input bit gaps);
		@(negedge clk);
		if (gaps) begin
			start <= 0;
			idle_gap();
		end
		start <= 1;
		in_item <= '{wealth: w, bid_amount: b, last_entry: last};
		@(posedge clk);
		while (busy) @(posedge clk);
		if (grid_count < DEPTH) begin
			grid_wealth[grid_count] = w;
			grid_bid[grid_count] = b;
			grid_count++;
		end
		if (last) predict_table();
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic set_omega(input logic [31:0] v);
		wait_idle();
		omega_we <= 1;
		omega <= v;
		@(negedge clk);
		omega_we <= 0;
		omega_model = v;
	endtask

	// mostly descending grid with random spacing and occasional random jumps, bids mostly inside the grid span
	task automatic send_grid(input int unsigned n, input bit gaps);
		logic [31:0] w, b;
		w = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom();
		for (int unsigned i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: b = $urandom();
				1: b = 0;
				default: b = $urandom() % (w / 2 + 1);
			endcase
			if ($urandom_range(0, 15) == 0) w = $urandom();
			send_entry(w, b, i + 1 == n, gaps);
			w = w - ($urandom_range(0, 7) == 0 ? 0 : $urandom() % (w / 4 + 1));
		end
	endtask

	task automatic test_directed();
		send_entry(32'h1000_0000, 32'h0100_0000, 1, 0);
		send_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
		send_entry(32'h8000_0000, 32'h0000_0000, 0, 0);
		send_entry(32'h8000_0000, 32'h4000_0000, 0, 0);
		send_entry(32'h0000_0000, 32'h0000_0001, 1, 0);
		set_omega(32'hFFFF_FFFF);
		send_entry(32'h4000_0000, 32'h1000_0000, 0, 0);
		send_entry(32'h2000_0000, 32'h3000_0000, 0, 0);
		send_entry(32'h0000_0001, 32'h0000_0000, 1, 0);
		set_omega(32'h0800_0000);
		send_entry(32'h1000_0000, 32'h2000_0000, 0, 0);
		send_entry(32'h3000_0000, 32'h0000_0000, 0, 0);
		send_entry(32'h0100_0000, 32'h0000_0000, 1, 0);
	endtask

	task automatic test_overflow();
		send_grid(DEPTH, 0);
		wait_idle();
		for (int i = 0; i < 66; i++)
			send_entry($urandom(), $urandom(), i == 65, 0);
	endtask

	task automatic test_random();
		int unsigned sent;
		sent = 0;
		while (sent < 290) begin
			int unsigned n;
			if (sent % 100 < 8) set_omega($urandom_range(0, 1) ? $urandom() : $urandom() >> 4);
			n = $urandom_range(0, 7) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 8);
			if ($urandom_range(0, 9) == 0) begin
				for (int i = 0; i < n; i++)
					send_entry($urandom(), $urandom(), i + 1 == n, 1);
			end else begin
				send_grid(n, $urandom_range(0, 3) != 0);
			end
			sent += n;
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_overflow();
		set_omega(0);
		test_random();
		wait_idle();
		if (fail_count == 0) $display("PASS wealth_transition_table_builder");
		else $display("FAIL wealth_transition_table_builder");
		$finish;
	end
endmodule
